// File: rtl/hkrd_pkg.sv
// hkrd_pkg: types and constants shared by the keyboard report diff block
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package hkrd_pkg;

  localparam int unsigned UsageW     = 8;
  localparam int unsigned ModBits    = 8;
  localparam int unsigned SlotCount  = 6;
  localparam int unsigned EventCount = ModBits + 2 * SlotCount;

  // bit positions of the release and press event groups inside a job mask; modifier events start at bit 0
  localparam int unsigned RelBase   = ModBits;
  localparam int unsigned PressBase = ModBits + SlotCount;

  localparam logic [UsageW-1:0] ModUsageBase = 8'hE0;

  typedef logic [SlotCount-1:0][UsageW-1:0] slots_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_word_t;

  typedef struct packed {
    logic       is_press;
    logic [7:0] usage_code;
    logic       last_event;
  } out_word_t;

  // lane results for one report, lowest set mask bit is emitted first
  typedef struct packed {
    logic [EventCount-1:0]             mask;
    logic [EventCount-1:0]             press;
    logic [EventCount-1:0][UsageW-1:0] usage;
  } job_t;

endpackage

// File: rtl/hid_keyboard_report_diff.sv
// hid_keyboard_report_diff: top level, boot keyboard report to key event words
// depends on hkrd_pkg, hkrd_lane, hkrd_serializer
`timescale 1ns / 1ps

// Takes one boot keyboard report word (modifier bitmap and six key slots) and
// emits one event word per changed key: modifier changes for bits 0 to 7 first
// (usage 0xE0 plus the bit), then releases of previous slots missing from the
// new report, then presses of new slots missing from the previous one, both in
// slot order. last_event marks the final word of a report; a report with no
// change gives no words. A report produces its words one per cycle while out_stall_i
// is low, up to 20 words, from the single output register of the merge stage. A new
// report is taken while the previous one is still being emitted: one report waits
// in the lane result register behind the one being serialized. The previous report
// is updated as each report is accepted and clears at reset.
module hid_keyboard_report_diff
  import hkrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // previous report
  logic [ModBits-1:0] prior_mods_q;
  slots_t             prior_slots_q;

  // lane result register, one job waiting for the serializer
  job_t job_q, job_d;
  logic job_valid_q, job_valid_d;
  logic job_take;
  logic in_accept;

  slots_t               new_slots;
  logic [SlotCount-1:0] rel_hit, press_hit;

  assign new_slots[0] = in_word_i.key_slot_0;
  assign new_slots[1] = in_word_i.key_slot_1;
  assign new_slots[2] = in_word_i.key_slot_2;
  assign new_slots[3] = in_word_i.key_slot_3;
  assign new_slots[4] = in_word_i.key_slot_4;
  assign new_slots[5] = in_word_i.key_slot_5;

  // stall while a job waits and the serializer cannot take it this cycle
  assign in_stall_o = job_valid_q && !job_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  // release lanes: each previous slot against the new report,
  // press lanes: each new slot against the previous report
  for (genvar g = 0; g < SlotCount; g++) begin : g_lane
    hkrd_lane u_rel (
      .usage_i (prior_slots_q[g]),
      .slots_i (new_slots),
      .hit_o   (rel_hit[g])
    );
    hkrd_lane u_press (
      .usage_i (new_slots[g]),
      .slots_i (prior_slots_q),
      .hit_o   (press_hit[g])
    );
  end

  // pack lane results in emission order
  always_comb begin
    job_d = '0;
    for (int i = 0; i < ModBits; i++) begin
      job_d.mask[i]  = prior_mods_q[i] ^ in_word_i.modifier_bits[i];
      job_d.press[i] = in_word_i.modifier_bits[i];
      job_d.usage[i] = ModUsageBase + UsageW'(i);
    end
    for (int i = 0; i < SlotCount; i++) begin
      job_d.mask[RelBase + i]    = rel_hit[i];
      job_d.press[RelBase + i]   = 1'b0;
      job_d.usage[RelBase + i]   = prior_slots_q[i];
      job_d.mask[PressBase + i]  = press_hit[i];
      job_d.press[PressBase + i] = 1'b1;
      job_d.usage[PressBase + i] = new_slots[i];
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    if (in_accept) begin
      job_valid_d = 1'b1;
    end else if (job_take) begin
      job_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q   <= 1'b0;
      prior_mods_q  <= '0;
      prior_slots_q <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      if (in_accept) begin
        prior_mods_q  <= in_word_i.modifier_bits;
        prior_slots_q <= new_slots;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      job_q <= job_d;
    end
  end

  // merge stage: walks the job mask, one event word per cycle while the output is not stalled
  hkrd_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_q),
    .job_valid_i (job_valid_q),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: rtl/hkrd_lane.sv
// hkrd_lane: one compare lane, flags a nonzero usage missing from a slot set
// depends on hkrd_pkg
`timescale 1ns / 1ps

module hkrd_lane
  import hkrd_pkg::*;
(
  input  logic [UsageW-1:0] usage_i,
  input  slots_t            slots_i,
  output logic              hit_o
);

  logic [SlotCount-1:0] match;

  always_comb begin
    for (int i = 0; i < SlotCount; i++) begin
      match[i] = (slots_i[i] == usage_i);
    end
  end

  assign hit_o = (usage_i != '0) && !(|match);

endmodule

// File: rtl/hkrd_serializer.sv
// hkrd_serializer: merges lane results of one job into words, one per cycle while the output is not stalled
// depends on hkrd_pkg
`timescale 1ns / 1ps

module hkrd_serializer
  import hkrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_take_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [EventCount-1:0]             mask_q, mask_d;
  logic [EventCount-1:0]             press_q;
  logic [EventCount-1:0][UsageW-1:0] usage_q;
  logic                              out_valid_q, out_valid_d;
  out_word_t                         out_word_q;

  logic                  active, out_ready, fire, load;
  logic [EventCount-1:0] pick, rem;
  logic [UsageW-1:0]     pick_usage;

  assign active    = |mask_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = active && out_ready;
  // lowest pending event
  assign pick      = mask_q & (~mask_q + 1'b1);
  assign rem       = mask_q & ~pick;
  assign load      = !active || (fire && (rem == '0));

  always_comb begin
    pick_usage = '0;
    for (int i = 0; i < EventCount; i++) begin
      pick_usage = pick_usage | (usage_q[i] & {UsageW{pick[i]}});
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = job_valid_i ? job_i.mask : '0;
    end else if (fire) begin
      mask_d = rem;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && job_valid_i) begin
      press_q <= job_i.press;
      usage_q <= job_i.usage;
    end
    if (fire) begin
      out_word_q.is_press   <= |(press_q & pick);
      out_word_q.usage_code <= pick_usage;
      out_word_q.last_event <= (rem == '0);
    end
  end

  assign job_take_o  = load;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
